// File: hw/rtl/ultrasonic_ranger_median_core_assert.svh
// Assertion macros shared by the ultrasonic ranger RTL.
`ifndef ULTRASONIC_RANGER_MEDIAN_CORE_ASSERT_SVH
`define ULTRASONIC_RANGER_MEDIAN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URM_ASSERT_SAME(lbl, clk_s, rst_ns, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URM_ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/urm_pkg.sv
// Types, constants and codes shared by the ultrasonic ranger modules.
package urm_pkg;

	localparam int NUM_MEASURES = 5;
	localparam int IDX_W        = (NUM_MEASURES > 1) ? $clog2(NUM_MEASURES) : 1;
	localparam int CNT_W        = $clog2(NUM_MEASURES + 1);
	localparam int MEDIAN_RANK  = NUM_MEASURES / 2;

	localparam int DIST_W  = 16;
	localparam int TICK_W  = 20;
	localparam int WIDTH_W = 21;
	localparam int REM_W   = 6;

	localparam logic [REM_W:0]       CM_DIVISOR   = 7'd58;
	localparam logic [REM_W:0]       REM_STEP     = 7'd10;
	localparam logic [WIDTH_W-1:0]   WIDTH_STEP   = 21'd10;
	localparam logic [TICK_W-1:0]    ECHO_BLOCK   = 20'd10;
	localparam logic signed [DIST_W-1:0] DIST_TIMEOUT = -16'sd1;

	localparam logic [7:0]        TRIG_LOW_RESET  = 8'd2;
	localparam logic [7:0]        TRIG_HIGH_RESET = 8'd10;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET   = 20'd1000000;
	localparam logic [TICK_W-1:0] GAP_RESET       = 20'd200000;

	typedef enum logic [1:0] {
		CFG_TRIG_LOW  = 2'd0,
		CFG_TRIG_HIGH = 2'd1,
		CFG_TIMEOUT   = 2'd2,
		CFG_GAP       = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TLOW  = 3'd1,
		PH_THIGH = 3'd2,
		PH_WAIT  = 3'd3,
		PH_ECHO  = 3'd4,
		PH_GAP   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		C_IDLE = 2'd0,
		C_STEP = 2'd1,
		C_MED  = 2'd2,
		C_PUT  = 2'd3
	} ctl_state_t;

	typedef enum logic [1:0] {
		M_IDLE = 2'd0,
		M_RDC  = 2'd1,
		M_LDC  = 2'd2,
		M_CMP  = 2'd3
	} med_state_t;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} urm_in_t;

	typedef struct packed {
		logic                     trig_level;
		logic                     busy_res;
		logic                     done_res;
		logic signed [DIST_W-1:0] distance_cm;
	} urm_out_t;

	typedef struct packed {
		logic [7:0]        trig_low_us;
		logic [7:0]        trig_high_us;
		logic [TICK_W-1:0] timeout_us;
		logic [TICK_W-1:0] gap_us;
	} urm_cfg_t;

	typedef struct packed {
		logic                     trig;
		logic                     busy;
		logic                     store_en;
		logic [IDX_W-1:0]         store_idx;
		logic signed [DIST_W-1:0] store_val;
		logic                     finish;
	} tick_res_t;

endpackage

// File: hw/rtl/urm_tick.sv
// Per-tick ranging sequencer: trigger timing, echo wait and echo width measurement.
module urm_tick (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  urm_pkg::urm_in_t    in_item,
	input  urm_pkg::urm_cfg_t   cfg,
	output urm_pkg::tick_res_t  res
);
	import urm_pkg::*;

	phase_t              phase_q, phase_d;
	logic [TICK_W-1:0]   ticks_q, ticks_d;
	logic [WIDTH_W-1:0]  width_q, width_d;
	logic [DIST_W-1:0]   quot_q, quot_d;
	logic [REM_W-1:0]    rem_q, rem_d;
	logic [CNT_W-1:0]    index_q, index_d;

	logic [TICK_W:0]     ticks_inc;
	logic [TICK_W-1:0]   echo_ticks;
	logic [WIDTH_W-1:0]  width_add;
	logic [REM_W:0]      rem_add;
	logic [CNT_W:0]      index_inc;
	logic                store_en;
	logic signed [DIST_W-1:0] store_val;
	logic                gap_done;
	logic                finish;

	// Next state of the ranging sequence for the tick held at the input.
	always_comb begin
		ticks_inc  = {1'b0, ticks_q} + (TICK_W+1)'(1);
		width_add  = width_q + WIDTH_STEP;
		rem_add    = {1'b0, rem_q} + REM_STEP;
		index_inc  = {1'b0, index_q} + (CNT_W+1)'(1);
		echo_ticks = ECHO_BLOCK;
		phase_d    = phase_q;
		ticks_d    = ticks_q;
		width_d    = width_q;
		quot_d     = quot_q;
		rem_d      = rem_q;
		index_d    = index_q;
		store_en   = 1'b0;
		store_val  = DIST_TIMEOUT;
		gap_done   = 1'b0;
		finish     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (in_item.start_req) begin
					index_d = '0;
					ticks_d = '0;
					phase_d = (cfg.trig_low_us == 8'd0) ? PH_THIGH : PH_TLOW;
				end
			end
			PH_TLOW: begin
				ticks_d = ticks_inc[TICK_W-1:0];
				if (ticks_inc >= (TICK_W+1)'(cfg.trig_low_us)) begin
					phase_d = PH_THIGH;
					ticks_d = '0;
				end
			end
			PH_THIGH: begin
				ticks_d = ticks_inc[TICK_W-1:0];
				if (ticks_inc >= (TICK_W+1)'(cfg.trig_high_us)) begin
					phase_d = PH_WAIT;
					ticks_d = '0;
				end
			end
			PH_WAIT: begin
				if (in_item.echo_level) begin
					phase_d = PH_ECHO;
					ticks_d = TICK_W'(1);
					width_d = '0;
					quot_d  = '0;
					rem_d   = '0;
				end else if (ticks_q >= cfg.timeout_us) begin
					store_en = 1'b1;
				end else begin
					ticks_d = ticks_inc[TICK_W-1:0];
				end
			end
			PH_ECHO: begin
				if ((ticks_q == '0) && !in_item.echo_level) begin
					store_en  = 1'b1;
					store_val = quot_q;
				end else begin
					// The echo is only sampled at the first tick of each ten-tick block.
					echo_ticks = (ticks_q == '0) ? TICK_W'(1) : ticks_inc[TICK_W-1:0];
					if (echo_ticks >= ECHO_BLOCK) begin
						ticks_d = '0;
						width_d = width_add;
						// Quotient and remainder by 58 follow the width as it grows.
						if (rem_add >= CM_DIVISOR) begin
							rem_d  = REM_W'(rem_add - CM_DIVISOR);
							quot_d = quot_q + DIST_W'(1);
						end else begin
							rem_d = rem_add[REM_W-1:0];
						end
						if (width_add > WIDTH_W'(cfg.timeout_us)) begin
							store_en = 1'b1;
						end
					end else begin
						ticks_d = echo_ticks;
					end
				end
			end
			PH_GAP: begin
				ticks_d = ticks_inc[TICK_W-1:0];
				if (ticks_inc >= (TICK_W+1)'(cfg.gap_us)) begin
					gap_done = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				ticks_d = '0;
			end
		endcase
		if (store_en) begin
			phase_d = PH_GAP;
			ticks_d = '0;
			if (cfg.gap_us == '0) begin
				gap_done = 1'b1;
			end
		end
		if (gap_done) begin
			ticks_d = '0;
			if (index_inc >= (CNT_W+1)'(NUM_MEASURES)) begin
				finish  = 1'b1;
				phase_d = PH_IDLE;
				index_d = '0;
			end else begin
				index_d = index_inc[CNT_W-1:0];
				phase_d = (cfg.trig_low_us == 8'd0) ? PH_THIGH : PH_TLOW;
			end
		end
	end

	always_comb begin
		res.trig      = (phase_q == PH_THIGH);
		res.busy      = (phase_d != PH_IDLE);
		res.store_en  = store_en;
		res.store_idx = index_q[IDX_W-1:0];
		res.store_val = store_val;
		res.finish    = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			width_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			index_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			width_q <= width_d;
			quot_q  <= quot_d;
			rem_q   <= rem_d;
			index_q <= index_d;
		end
	end

endmodule

// File: hw/rtl/urm_median.sv
// Measurement store and median selection through one shared signed comparator.
module urm_median (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [urm_pkg::IDX_W-1:0]               wr_idx,
	input  logic signed [urm_pkg::DIST_W-1:0]       wr_data,
	input  logic                                    start,
	output logic                                    done,
	output logic signed [urm_pkg::DIST_W-1:0]       median
);
	import urm_pkg::*;

	logic signed [DIST_W-1:0] mem [NUM_MEASURES];
	logic signed [DIST_W-1:0] rdata_q;
	logic [IDX_W-1:0]         rd_addr;

	med_state_t               state_q, state_d;
	logic [IDX_W-1:0]         cand_idx_q;
	logic [IDX_W-1:0]         cmp_idx_q;
	logic signed [DIST_W-1:0] cand_q;
	logic [CNT_W-1:0]         less_q, less_d;
	logic [CNT_W-1:0]         le_q, le_d;
	logic                     lt, eq;
	logic                     last_cmp;
	logic                     found;
	logic                     sel_done;
	logic                     done_q;
	logic signed [DIST_W-1:0] median_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// A candidate is the median when fewer than RANK+1 values lie below it
	// and more than RANK values lie at or below it, or when it is the last candidate.
	always_comb begin
		lt       = (rdata_q < cand_q);
		eq       = (rdata_q == cand_q);
		less_d   = less_q + CNT_W'(lt);
		le_d     = le_q + CNT_W'(lt | eq);
		last_cmp = (cmp_idx_q == IDX_W'(NUM_MEASURES - 1));
		found    = ((less_d <= CNT_W'(MEDIAN_RANK)) && (le_d > CNT_W'(MEDIAN_RANK)))
			|| (cand_idx_q == IDX_W'(NUM_MEASURES - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: if (start) state_d = M_RDC;
			M_RDC:  state_d = M_LDC;
			M_LDC:  state_d = M_CMP;
			M_CMP: begin
				if (last_cmp) begin
					state_d = found ? M_IDLE : M_RDC;
				end
			end
			default: state_d = M_IDLE;
		endcase
	end

	always_comb begin
		rd_addr  = '0;
		sel_done = 1'b0;
		unique case (state_q)
			M_RDC: rd_addr = cand_idx_q;
			M_LDC: rd_addr = '0;
			M_CMP: begin
				rd_addr  = last_cmp ? '0 : cmp_idx_q + IDX_W'(1);
				sel_done = last_cmp && found;
			end
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= M_IDLE;
			cand_idx_q <= '0;
			cmp_idx_q  <= '0;
			less_q     <= '0;
			le_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= sel_done;
			if (state_q == M_IDLE && start) begin
				cand_idx_q <= '0;
			end
			if (state_q == M_LDC) begin
				cmp_idx_q <= '0;
				less_q    <= '0;
				le_q      <= '0;
			end
			if (state_q == M_CMP) begin
				less_q <= less_d;
				le_q   <= le_d;
				if (!last_cmp) begin
					cmp_idx_q <= cmp_idx_q + IDX_W'(1);
				end else if (!found) begin
					cand_idx_q <= cand_idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_LDC) begin
			cand_q <= rdata_q;
		end
		if (sel_done) begin
			median_q <= cand_q;
		end
	end

	assign done   = done_q;
	assign median = median_q;

endmodule

// File: hw/rtl/ultrasonic_ranger_median_core.sv
// Top level of the ultrasonic ranger with median-of-measurements output.
//
// Each request on the input channel is one microsecond tick carrying the start
// request and the sampled echo level; each tick yields exactly one request on
// the output channel with the trigger level, the busy flag, the done flag and,
// when done, the median distance in centimetres (-1 for a timeout).
// An input request is taken when in_valid is high and in_stall is low.
// An ordinary tick passes through capture, sequence update and hand-over to the
// output register. The tick that ends the last gap also runs the median
// selection over the stored values through one comparator before its hand-over.
// Results leave through an output register, so the next tick is taken while a
// result still waits; a stall on the output holds that register, and the
// block then holds its next result until the register frees.
// Configuration writes are taken on every cycle (cfg_ready is high) and must
// arrive only while no tick is in flight.
// Reset clears the sequence to idle and loads the default timings; the
// measurement store is not cleared, as every slot is written before use.
`include "ultrasonic_ranger_median_core_assert.svh"

module ultrasonic_ranger_median_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  urm_pkg::urm_in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output urm_pkg::urm_out_t  out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data
);
	import urm_pkg::*;

	urm_cfg_t                 cfg_q;
	urm_in_t                  in_q;
	urm_out_t                 res_q;
	urm_out_t                 out_q;
	logic                     out_valid_q;
	ctl_state_t               state_q, state_d;
	tick_res_t                tick;
	logic                     accept;
	logic                     step;
	logic                     med_start;
	logic                     med_done;
	logic signed [DIST_W-1:0] med_value;
	logic                     out_free;
	logic                     load_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_low_us  <= TRIG_LOW_RESET;
			cfg_q.trig_high_us <= TRIG_HIGH_RESET;
			cfg_q.timeout_us   <= TIMEOUT_RESET;
			cfg_q.gap_us       <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TRIG_LOW:  cfg_q.trig_low_us  <= cfg_data[7:0];
				CFG_TRIG_HIGH: cfg_q.trig_high_us <= cfg_data[7:0];
				CFG_TIMEOUT:   cfg_q.timeout_us   <= cfg_data;
				CFG_GAP:       cfg_q.gap_us       <= cfg_data;
				default:       cfg_q.gap_us       <= cfg_q.gap_us;
			endcase
		end
	end

	urm_tick u_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_item (in_q),
		.cfg     (cfg_q),
		.res     (tick)
	);

	urm_median u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (step && tick.store_en),
		.wr_idx  (tick.store_idx),
		.wr_data (tick.store_val),
		.start   (med_start),
		.done    (med_done),
		.median  (med_value)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (in_valid) state_d = C_STEP;
			C_STEP: state_d = tick.finish ? C_MED : C_PUT;
			C_MED:  if (med_done) state_d = C_PUT;
			C_PUT:  if (out_free) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != C_IDLE);
		accept    = in_valid && !in_stall;
		step      = (state_q == C_STEP);
		med_start = step && tick.finish;
		load_out  = (state_q == C_PUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		if (step) begin
			res_q.trig_level  <= tick.trig;
			res_q.busy_res    <= tick.busy;
			res_q.done_res    <= 1'b0;
			res_q.distance_cm <= '0;
		end else if (state_q == C_MED && med_done) begin
			res_q.trig_level  <= 1'b0;
			res_q.busy_res    <= 1'b0;
			res_q.done_res    <= 1'b1;
			res_q.distance_cm <= med_value;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`URM_ASSERT_NEXT(a_accept_steps, clk, arst_n, accept, state_q == C_STEP, "accepted tick not stepped")
	`URM_ASSERT_SAME(a_med_done_waited, clk, arst_n, med_done, state_q == C_MED, "median with no waiting tick")
	`URM_ASSERT_SAME(a_done_not_busy, clk, arst_n, out_valid && out_data.done_res, !out_data.busy_res, "done result flagged busy")
	`URM_ASSERT_SAME(a_dist_zero, clk, arst_n, out_valid && !out_data.done_res, out_data.distance_cm == '0, "distance given without done")

endmodule
